// ----- sv/ibp_pkg.sv -----
// Shared types, constants and the control-store program of the indexed bag partition.
// No dependencies; ibp_seq and indexed_bag_partition import this package, ibp_ram does not.
package ibp_pkg;

    // Sizes of the element and bag spaces
    localparam int NUM_ELEMENTS = 64;
    localparam int NUM_BAGS     = 16;

    localparam int ELEM_W  = 6;               // element identifier, slot index
    localparam int BAG_W   = 4;               // logical or physical bag number
    localparam int LEN_W   = 7;               // bag length, 0 .. NUM_ELEMENTS
    localparam int CNT_W   = 5;               // bag count, 0 .. NUM_BAGS
    localparam int OP_W    = 4;
    localparam int SLOT_AW = BAG_W + ELEM_W;  // slot store address
    localparam int PC_W    = 6;
    localparam int UCODE_LEN = 55;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
    localparam logic [OP_W-1:0] OP_MOVE     = 4'd1;
    localparam logic [OP_W-1:0] OP_CONTAIN  = 4'd2;
    localparam logic [OP_W-1:0] OP_SWAP     = 4'd3;
    localparam logic [OP_W-1:0] OP_REMOVE   = 4'd4;
    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd5;
    localparam logic [OP_W-1:0] OP_SETCOUNT = 4'd6;
    localparam logic [OP_W-1:0] OP_READ     = 4'd7;
    localparam logic [OP_W-1:0] OP_LENGTH   = 4'd8;

    // Entry points and jump targets in the control store
    localparam logic [PC_W-1:0] PC_ERR      = 6'd0;
    localparam logic [PC_W-1:0] PC_TAIL     = 6'd1;
    localparam logic [PC_W-1:0] PC_ADD      = 6'd3;
    localparam logic [PC_W-1:0] PC_MOVE     = 6'd8;
    localparam logic [PC_W-1:0] PC_CONTAIN  = 6'd23;
    localparam logic [PC_W-1:0] PC_SWAP     = 6'd30;
    localparam logic [PC_W-1:0] PC_REMOVE   = 6'd35;
    localparam logic [PC_W-1:0] PC_CLEAR    = 6'd41;
    localparam logic [PC_W-1:0] PC_SETCOUNT = 6'd42;
    localparam logic [PC_W-1:0] PC_SC_LOOP  = 6'd44;
    localparam logic [PC_W-1:0] PC_SC_DONE  = 6'd46;
    localparam logic [PC_W-1:0] PC_READ     = 6'd47;
    localparam logic [PC_W-1:0] PC_LENGTH   = 6'd53;

    // Command and result transactions
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ELEM_W-1:0] element;
        logic [BAG_W-1:0]  first_bag;
        logic [BAG_W-1:0]  second_bag;
        logic [ELEM_W-1:0] slot_position;
        logic [CNT_W-1:0]  new_bag_count;
    } cmd_t;

    typedef struct packed {
        logic              found;
        logic [ELEM_W-1:0] slot_element;
        logic [LEN_W-1:0]  bag_length;
        logic [CNT_W-1:0]  bag_count;
        logic              error;
    } res_t;

    // Datapath actions, one per control word
    typedef enum logic [4:0] {
        A_NOP,
        A_SET_ERR,
        A_LD_PA,         // pa <= map[first_bag]
        A_LD_PB,         // pb <= map[second_bag]
        A_LD_PB_LAST,    // pb <= map[count - 1]
        A_LD_LENA,       // lena <= length[pa]
        A_LD_LENB,       // lenb <= length[pb]
        A_RD_POS,        // issue position read for the element
        A_CAP_POS,       // capture element position
        A_RD_SLOT_HELD,  // issue slot read at (pa, position)
        A_RD_SLOT_LAST,  // issue slot read at (pa, lena - 1)
        A_CAP_LAST,
        A_FILL_GAP,      // move last element into the gap, shrink bag pa
        A_APPEND,        // append element to bag pb
        A_SET_FOUND,
        A_WR_MAP_A,      // map[first_bag] <= pb
        A_WR_MAP_B,      // map[second_bag] <= pa
        A_WR_MAP_LAST,   // map[count - 1] <= pa
        A_DROP_BAG,      // empty bag pa, count - 1
        A_CLR_COUNT,
        A_INIT_ITER,
        A_CLR_LEN_ITER,  // empty bag map[iter], iter + 1
        A_SET_COUNT,
        A_RD_SLOT_POS,   // issue slot read at (pa, slot_position)
        A_CAP_SLOT,
        A_EMIT
    } act_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_BAD_A,
        C_BAD_B,
        C_BAD_AB,
        C_LENB_FULL,
        C_NOT_HELD,
        C_MOVE_FULL,
        C_WANT_BIG,
        C_ITER_DONE,
        C_POS_BEYOND
    } cond_t;

    typedef struct packed {
        act_t              act;
        cond_t             cond;
        logic [PC_W-1:0]   target;
    } uword_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic bad_a;
        logic bad_b;
        logic lenb_full;
        logic not_held;
        logic move_full;
        logic want_big;
        logic iter_done;
        logic pos_beyond;
        logic res_free;
    } ibp_flags_t;

    function automatic uword_t uw(act_t a, cond_t c, logic [PC_W-1:0] t);
        uword_t w;
        w.act    = a;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    // Entry point of each operation's program
    function automatic logic [PC_W-1:0] ibp_entry(logic [OP_W-1:0] op);
        logic [PC_W-1:0] pc;
        unique case (op)
            OP_ADD:      pc = PC_ADD;
            OP_MOVE:     pc = PC_MOVE;
            OP_CONTAIN:  pc = PC_CONTAIN;
            OP_SWAP:     pc = PC_SWAP;
            OP_REMOVE:   pc = PC_REMOVE;
            OP_CLEAR:    pc = PC_CLEAR;
            OP_SETCOUNT: pc = PC_SETCOUNT;
            OP_READ:     pc = PC_READ;
            OP_LENGTH:   pc = PC_LENGTH;
            default:     pc = PC_ERR;
        endcase
        return pc;
    endfunction

    // Control store
    function automatic uword_t ibp_ucode(logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            // refused operation, then common tail: reload pa, emit result
            6'd0:  w = uw(A_SET_ERR,      C_ALWAYS,     PC_TAIL);
            6'd1:  w = uw(A_LD_PA,        C_NEXT,       PC_ERR);
            6'd2:  w = uw(A_EMIT,         C_NEXT,       PC_ERR);
            // add
            6'd3:  w = uw(A_NOP,          C_BAD_B,      PC_ERR);
            6'd4:  w = uw(A_LD_PB,        C_NEXT,       PC_ERR);
            6'd5:  w = uw(A_LD_LENB,      C_NEXT,       PC_ERR);
            6'd6:  w = uw(A_NOP,          C_LENB_FULL,  PC_ERR);
            6'd7:  w = uw(A_APPEND,       C_ALWAYS,     PC_TAIL);
            // move
            6'd8:  w = uw(A_NOP,          C_BAD_AB,     PC_ERR);
            6'd9:  w = uw(A_LD_PA,        C_NEXT,       PC_ERR);
            6'd10: w = uw(A_LD_PB,        C_NEXT,       PC_ERR);
            6'd11: w = uw(A_LD_LENA,      C_NEXT,       PC_ERR);
            6'd12: w = uw(A_LD_LENB,      C_NEXT,       PC_ERR);
            6'd13: w = uw(A_RD_POS,       C_NEXT,       PC_ERR);
            6'd14: w = uw(A_CAP_POS,      C_NEXT,       PC_ERR);
            6'd15: w = uw(A_RD_SLOT_HELD, C_NEXT,       PC_ERR);
            6'd16: w = uw(A_NOP,          C_NOT_HELD,   PC_ERR);
            6'd17: w = uw(A_NOP,          C_MOVE_FULL,  PC_ERR);
            6'd18: w = uw(A_RD_SLOT_LAST, C_NEXT,       PC_ERR);
            6'd19: w = uw(A_CAP_LAST,     C_NEXT,       PC_ERR);
            6'd20: w = uw(A_FILL_GAP,     C_NEXT,       PC_ERR);
            6'd21: w = uw(A_LD_LENB,      C_NEXT,       PC_ERR);
            6'd22: w = uw(A_APPEND,       C_ALWAYS,     PC_TAIL);
            // contain
            6'd23: w = uw(A_NOP,          C_BAD_A,      PC_ERR);
            6'd24: w = uw(A_LD_PA,        C_NEXT,       PC_ERR);
            6'd25: w = uw(A_LD_LENA,      C_NEXT,       PC_ERR);
            6'd26: w = uw(A_RD_POS,       C_NEXT,       PC_ERR);
            6'd27: w = uw(A_CAP_POS,      C_NEXT,       PC_ERR);
            6'd28: w = uw(A_RD_SLOT_HELD, C_NEXT,       PC_ERR);
            6'd29: w = uw(A_SET_FOUND,    C_ALWAYS,     PC_TAIL);
            // swap
            6'd30: w = uw(A_NOP,          C_BAD_AB,     PC_ERR);
            6'd31: w = uw(A_LD_PA,        C_NEXT,       PC_ERR);
            6'd32: w = uw(A_LD_PB,        C_NEXT,       PC_ERR);
            6'd33: w = uw(A_WR_MAP_A,     C_NEXT,       PC_ERR);
            6'd34: w = uw(A_WR_MAP_B,     C_ALWAYS,     PC_TAIL);
            // remove bag
            6'd35: w = uw(A_NOP,          C_BAD_A,      PC_ERR);
            6'd36: w = uw(A_LD_PA,        C_NEXT,       PC_ERR);
            6'd37: w = uw(A_LD_PB_LAST,   C_NEXT,       PC_ERR);
            6'd38: w = uw(A_WR_MAP_A,     C_NEXT,       PC_ERR);
            6'd39: w = uw(A_WR_MAP_LAST,  C_NEXT,       PC_ERR);
            6'd40: w = uw(A_DROP_BAG,     C_ALWAYS,     PC_TAIL);
            // clear
            6'd41: w = uw(A_CLR_COUNT,    C_ALWAYS,     PC_TAIL);
            // set count: empty each bag that grows into use
            6'd42: w = uw(A_NOP,          C_WANT_BIG,   PC_ERR);
            6'd43: w = uw(A_INIT_ITER,    C_NEXT,       PC_ERR);
            6'd44: w = uw(A_NOP,          C_ITER_DONE,  PC_SC_DONE);
            6'd45: w = uw(A_CLR_LEN_ITER, C_ALWAYS,     PC_SC_LOOP);
            6'd46: w = uw(A_SET_COUNT,    C_ALWAYS,     PC_TAIL);
            // read slot
            6'd47: w = uw(A_NOP,          C_BAD_A,      PC_ERR);
            6'd48: w = uw(A_LD_PA,        C_NEXT,       PC_ERR);
            6'd49: w = uw(A_LD_LENA,      C_NEXT,       PC_ERR);
            6'd50: w = uw(A_NOP,          C_POS_BEYOND, PC_ERR);
            6'd51: w = uw(A_RD_SLOT_POS,  C_NEXT,       PC_ERR);
            6'd52: w = uw(A_CAP_SLOT,     C_ALWAYS,     PC_TAIL);
            // length
            6'd53: w = uw(A_NOP,          C_BAD_A,      PC_ERR);
            6'd54: w = uw(A_NOP,          C_ALWAYS,     PC_TAIL);
            default: w = uw(A_NOP,        C_ALWAYS,     PC_ERR);
        endcase
        return w;
    endfunction

endpackage

// ----- sv/ibp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ibp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ibp_seq.sv -----
// Microcode sequencer: step counter, control-store lookup and conditional jumps.
// Depends on ibp_pkg for the control word, actions, conditions and the program.
module ibp_seq import ibp_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] opcode,
    input  ibp_flags_t      flags,
    output act_t            act,
    output logic            busy
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          word;
    logic            jump;
    logic            hold;

    assign word = ibp_ucode(pc_reg);

    // Evaluate the jump condition of the current step
    always_comb
    begin
        unique case (word.cond)
            C_NEXT:       jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_BAD_A:      jump = flags.bad_a;
            C_BAD_B:      jump = flags.bad_b;
            C_BAD_AB:     jump = flags.bad_a | flags.bad_b;
            C_LENB_FULL:  jump = flags.lenb_full;
            C_NOT_HELD:   jump = flags.not_held;
            C_MOVE_FULL:  jump = flags.move_full;
            C_WANT_BIG:   jump = flags.want_big;
            C_ITER_DONE:  jump = flags.iter_done;
            C_POS_BEYOND: jump = flags.pos_beyond;
            default:      jump = 1'b0;
        endcase
    end

    // Hold on the emit step until the result register is free
    assign hold = (word.act == A_EMIT) && !flags.res_free;

    // Advance the step counter
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        act       = A_NOP;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = ibp_entry(opcode);
        end
        else if (busy_reg && !hold)
        begin
            act = word.act;
            if (word.act == A_EMIT)
            begin
                busy_next = 1'b0;
            end
            else if (jump)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_ERR;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy = busy_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("ibp_seq: transaction started while busy");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg < PC_W'(UCODE_LEN)))
        else $error("ibp_seq: step counter outside the program");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (act == A_EMIT) |-> flags.res_free)
        else $error("ibp_seq: result emitted over a pending result");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (act == A_EMIT) |=> !busy_reg)
        else $error("ibp_seq: sequencer still busy after emit");

endmodule

// ----- sv/indexed_bag_partition.sv -----
// Indexed bag partition: elements kept in up to NUM_BAGS bags through a logical-to-physical
// bag map. One command transaction is taken at a time and runs as a short microprogram
// (ibp_seq) over the slot store RAM, the element position RAM and flop-based bag tables;
// the block stalls commands while a program runs. Set count runs one loop pass per bag
// brought into use, and a refused command jumps to the common error tail. The emit step
// waits while the previous result is still held by a stall at the output. The result sits
// in an output register, so the next command is accepted the cycle after its result is
// written, even while it waits.
// Depends on ibp_pkg, ibp_ram and ibp_seq.
module indexed_bag_partition import ibp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    // Control state
    logic [BAG_W-1:0]        map_reg  [NUM_BAGS];
    logic [LEN_W-1:0]        plen_reg [NUM_BAGS];
    logic [CNT_W-1:0]        count_reg;
    logic [NUM_ELEMENTS-1:0] epos_valid_reg;
    logic                    res_valid_reg;

    // Transaction scratch registers
    cmd_t              cmd_reg;
    logic [BAG_W-1:0]  pa_reg, pb_reg;
    logic [LEN_W-1:0]  lena_reg, lenb_reg, epos_reg;
    logic [ELEM_W-1:0] last_reg, slotel_reg;
    logic [CNT_W-1:0]  iter_reg;
    logic              err_reg, found_reg;
    res_t              res_reg;

    act_t       act;
    logic       busy;
    logic       start;
    ibp_flags_t flags;

    logic              a_ok, b_ok, held, lenb_full;
    logic [LEN_W-1:0]  lena_dec;
    logic [CNT_W-1:0]  count_dec;
    logic [BAG_W-1:0]  map_rd_addr, map_rd;
    logic [BAG_W-1:0]  plen_rd_addr;
    logic [LEN_W-1:0]  plen_rd;

    logic               slot_we, slot_re;
    logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
    logic [ELEM_W-1:0]  slot_wdata, slot_rdata;
    logic               pos_we, pos_re;
    logic [ELEM_W-1:0]  pos_waddr, pos_raddr;
    logic [LEN_W-1:0]   pos_wdata, pos_rdata;

    assign start     = cmd_valid && !busy;
    assign cmd_stall = busy;

    // Status for the sequencer
    assign a_ok      = {1'b0, cmd_reg.first_bag} < count_reg;
    assign b_ok      = {1'b0, cmd_reg.second_bag} < count_reg;
    assign held      = (epos_reg < lena_reg) && (slot_rdata == cmd_reg.element);
    assign lenb_full = lenb_reg >= LEN_W'(NUM_ELEMENTS);
    assign lena_dec  = lena_reg - LEN_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        flags.bad_a      = !a_ok;
        flags.bad_b      = !b_ok;
        flags.lenb_full  = lenb_full;
        flags.not_held   = !held;
        flags.move_full  = (pa_reg != pb_reg) && lenb_full;
        flags.want_big   = cmd_reg.new_bag_count > CNT_W'(NUM_BAGS);
        flags.iter_done  = iter_reg >= cmd_reg.new_bag_count;
        flags.pos_beyond = {1'b0, cmd_reg.slot_position} >= lena_reg;
        flags.res_free   = !res_valid_reg || !res_stall;
    end

    ibp_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (cmd.opcode),
        .flags  (flags),
        .act    (act),
        .busy   (busy)
    );

    // Single read port of the bag map
    always_comb
    begin
        unique case (act)
            A_LD_PB:        map_rd_addr = cmd_reg.second_bag;
            A_LD_PB_LAST:   map_rd_addr = count_dec[BAG_W-1:0];
            A_CLR_LEN_ITER: map_rd_addr = iter_reg[BAG_W-1:0];
            default:        map_rd_addr = cmd_reg.first_bag;
        endcase
    end
    assign map_rd = map_reg[map_rd_addr];

    // Single read port of the length table
    always_comb
    begin
        unique case (act)
            A_LD_LENB: plen_rd_addr = pb_reg;
            default:   plen_rd_addr = pa_reg;
        endcase
    end
    assign plen_rd = plen_reg[plen_rd_addr];

    // Drive the slot store and position RAM ports
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = {pb_reg, lenb_reg[ELEM_W-1:0]};
        slot_wdata = cmd_reg.element;
        slot_re    = 1'b0;
        slot_raddr = {pa_reg, epos_reg[ELEM_W-1:0]};
        pos_we     = 1'b0;
        pos_waddr  = cmd_reg.element;
        pos_wdata  = lenb_reg;
        pos_re     = 1'b0;
        pos_raddr  = cmd_reg.element;
        unique case (act)
            A_RD_POS:
            begin
                pos_re = 1'b1;
            end
            A_RD_SLOT_HELD:
            begin
                slot_re = 1'b1;
            end
            A_RD_SLOT_LAST:
            begin
                slot_re    = 1'b1;
                slot_raddr = {pa_reg, lena_dec[ELEM_W-1:0]};
            end
            A_RD_SLOT_POS:
            begin
                slot_re    = 1'b1;
                slot_raddr = {pa_reg, cmd_reg.slot_position};
            end
            A_FILL_GAP:
            begin
                slot_we    = 1'b1;
                slot_waddr = {pa_reg, epos_reg[ELEM_W-1:0]};
                slot_wdata = last_reg;
                pos_we     = 1'b1;
                pos_waddr  = last_reg;
                pos_wdata  = epos_reg;
            end
            A_APPEND:
            begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    ibp_ram #(.WIDTH(ELEM_W), .DEPTH(NUM_BAGS * NUM_ELEMENTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ibp_ram #(.WIDTH(LEN_W), .DEPTH(NUM_ELEMENTS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // Bag tables, bag count, position valid bits, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BAGS; i++)
            begin
                map_reg[i]  <= BAG_W'(i);
                plen_reg[i] <= '0;
            end
            count_reg      <= '0;
            epos_valid_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            // Raise result valid on emit, drop it once the result is taken
            if (act == A_EMIT)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (pos_we)
            begin
                epos_valid_reg[pos_waddr] <= 1'b1;
            end
            unique case (act)
                A_FILL_GAP:     plen_reg[pa_reg] <= lena_dec;
                A_APPEND:       plen_reg[pb_reg] <= lenb_reg + LEN_W'(1);
                A_WR_MAP_A:     map_reg[cmd_reg.first_bag] <= pb_reg;
                A_WR_MAP_B:     map_reg[cmd_reg.second_bag] <= pa_reg;
                A_WR_MAP_LAST:  map_reg[count_dec[BAG_W-1:0]] <= pa_reg;
                A_DROP_BAG:
                begin
                    plen_reg[pa_reg] <= '0;
                    count_reg        <= count_dec;
                end
                A_CLR_COUNT:    count_reg <= '0;
                A_CLR_LEN_ITER: plen_reg[map_rd] <= '0;
                A_SET_COUNT:    count_reg <= cmd_reg.new_bag_count;
                default:
                begin
                end
            endcase
        end
    end

    // Transaction scratch and result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg    <= cmd;
            err_reg    <= 1'b0;
            found_reg  <= 1'b0;
            slotel_reg <= '0;
        end
        unique case (act)
            A_SET_ERR:      err_reg <= 1'b1;
            A_LD_PA:        pa_reg <= map_rd;
            A_LD_PB:        pb_reg <= map_rd;
            A_LD_PB_LAST:   pb_reg <= map_rd;
            A_LD_LENA:      lena_reg <= plen_rd;
            A_LD_LENB:      lenb_reg <= plen_rd;
            A_CAP_POS:
            begin
                epos_reg <= epos_valid_reg[cmd_reg.element] ? pos_rdata
                                                            : LEN_W'(NUM_ELEMENTS);
            end
            A_CAP_LAST:     last_reg <= slot_rdata;
            A_SET_FOUND:    found_reg <= held;
            A_INIT_ITER:    iter_reg <= count_reg;
            A_CLR_LEN_ITER: iter_reg <= iter_reg + CNT_W'(1);
            A_CAP_SLOT:     slotel_reg <= slot_rdata;
            A_EMIT:
            begin
                res_reg.found        <= found_reg;
                res_reg.slot_element <= slotel_reg;
                res_reg.bag_length   <= a_ok ? plen_rd : '0;
                res_reg.bag_count    <= count_reg;
                res_reg.error        <= err_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_BAGS))
        else $error("indexed_bag_partition: bag count beyond table size");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("indexed_bag_partition: stalled result transaction changed");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (act == A_APPEND) |-> (lenb_reg < LEN_W'(NUM_ELEMENTS)))
        else $error("indexed_bag_partition: append into a full bag");

endmodule
